>>> sv/mtdq_pkg.sv
// Package for the multi-timer deadline queue: opcodes, result codes, slot record
// and the command/status structs between controller and datapath. No dependencies.
package mtdq_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int NRES_W      = 5;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_ADD_REL = 2'd1,
    CMD_ADD_ABS = 2'd2,
    CMD_CANCEL  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_MISS      = 3'd3,
    KIND_EXPIRED   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    HND_OWN     = 2'd0,
    HND_DEFAULT = 2'd1,
    HND_NONE    = 2'd2
  } handler_t;

  localparam logic [0:0] CFG_ENABLE  = 1'b0;
  localparam logic [0:0] CFG_DEFAULT = 1'b1;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] due;
    logic [30:0] period;
    logic        periodic;
    logic        own;
  } slot_t;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_step;
    logic take_best;
    logic emit_pend;
    logic emit_last;
    logic add_do;
    logic cancel_do;
  } ctl_cmd_t;

  typedef struct packed {
    opcode_t in_op;
    logic    en;
    logic    is_tick;
    logic    scan_done;
    logic    best_found;
    logic    have_pend;
    logic    cap_next;
    logic    out_free;
  } ctl_stat_t;

endpackage

>>> sv/mtdq_if.sv
// Channel interfaces of the multi-timer deadline queue: command input,
// result output and configuration write. No dependencies.
interface mtdq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [30:0] duration;
  logic        periodic;
  logic [31:0] deadline;
  logic [15:0] timer_id;
  logic        own_handler;
  modport source(output valid, command, duration, periodic, deadline, timer_id,
                 own_handler, input ready);
  modport sink(input valid, command, duration, periodic, deadline, timer_id,
               own_handler, output ready);
endinterface

interface mtdq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] id;
  logic [31:0] due_time;
  logic [1:0]  handler;
  logic        last;
  modport source(output valid, kind, id, due_time, handler, last, input ready);
  modport sink(input valid, kind, id, due_time, handler, last, output ready);
endinterface

interface mtdq_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [0:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> sv/mtdq_dp.sv
// Datapath of the multi-timer deadline queue: slot memory, time and id counters,
// slot scan, pending expiry and output register. Depends on mtdq_pkg.
module mtdq_dp import mtdq_pkg::*; #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_cmd_t    cmd,
  output ctl_stat_t   stat,
  input  logic [1:0]  in_command,
  input  logic [30:0] in_duration,
  input  logic        in_periodic,
  input  logic [31:0] in_deadline,
  input  logic [15:0] in_timer_id,
  input  logic        in_own_handler,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [0:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [15:0] out_id,
  output logic [31:0] out_due_time,
  output logic [1:0]  out_handler,
  output logic        out_last
);

  localparam int IW = $clog2(TIMER_SLOTS);
  localparam logic [IW:0] SLOTS_C = (IW+1)'(TIMER_SLOTS);

  logic en_r, dflt_r;
  logic [31:0] now_r;
  logic [15:0] next_id_r;
  logic [TIMER_SLOTS-1:0] valid_r, done_r;
  logic [NRES_W-1:0] nres_r;
  logic have_pend_r;

  opcode_t     op_r;
  logic [30:0] dur_r;
  logic        per_r;
  logic [31:0] dl_r;
  logic [15:0] tid_r;
  logic        own_r;

  slot_t mem [TIMER_SLOTS];
  slot_t rd_data_r;
  logic [IW:0] ra_r;
  logic rv_r;
  logic [IW-1:0] ri_r;

  logic best_found_r;
  logic [IW-1:0] best_idx_r;
  slot_t best_rec_r;
  logic [31:0] best_d_r;
  slot_t pend_rec_r;

  logic out_valid_r, out_last_r;
  kind_t out_kind_r;
  logic [15:0] out_id_r;
  logic [31:0] out_due_r;
  handler_t out_handler_r;

  logic rd_en, mem_we, free_found, hit, out_free;
  logic [IW-1:0] mem_wa, free_idx;
  slot_t mem_wd;
  logic [31:0] d, add_due;
  handler_t pend_hnd;

  assign out_free = !out_valid_r || out_ready;
  assign rd_en    = cmd.scan_step && (ra_r < SLOTS_C);
  assign d        = rd_data_r.due - now_r;
  assign add_due  = (op_r == CMD_ADD_REL) ? now_r + {1'b0, dur_r} : dl_r;
  assign pend_hnd = pend_rec_r.own ? HND_OWN : (dflt_r ? HND_DEFAULT : HND_NONE);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    if (op_r == CMD_CANCEL) begin
      hit = rv_r && valid_r[ri_r] && (rd_data_r.id == tid_r) && !best_found_r;
    end else begin
      hit = rv_r && valid_r[ri_r] && !done_r[ri_r] && d[31] &&
            (!best_found_r || d < best_d_r ||
             (d == best_d_r && rd_data_r.id < best_rec_r.id));
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = free_idx;
    mem_wd = best_rec_r;
    if (cmd.add_do && free_found) begin
      mem_we      = 1'b1;
      mem_wd.id   = next_id_r;
      mem_wd.own  = own_r;
      mem_wd.due  = add_due;
      if (op_r == CMD_ADD_REL) begin
        mem_wd.period   = dur_r;
        mem_wd.periodic = per_r;
      end else begin
        mem_wd.period   = '0;
        mem_wd.periodic = 1'b0;
      end
    end else if (cmd.take_best && best_rec_r.periodic) begin
      mem_we     = 1'b1;
      mem_wa     = best_idx_r;
      mem_wd.due = best_rec_r.due + {1'b0, best_rec_r.period};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[ra_r[IW-1:0]];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= opcode_t'(in_command);
      dur_r <= in_duration;
      per_r <= in_periodic;
      dl_r  <= in_deadline;
      tid_r <= in_timer_id;
      own_r <= in_own_handler;
    end
    if (cmd.scan_step && rd_en) begin
      ri_r <= ra_r[IW-1:0];
    end
    if (cmd.scan_step && hit) begin
      best_idx_r <= ri_r;
      best_rec_r <= rd_data_r;
      best_d_r   <= d;
    end
    if (cmd.take_best) begin
      pend_rec_r <= best_rec_r;
    end
    if (cmd.emit_pend) begin
      out_kind_r    <= KIND_EXPIRED;
      out_id_r      <= pend_rec_r.id;
      out_due_r     <= pend_rec_r.due;
      out_handler_r <= pend_hnd;
      out_last_r    <= cmd.emit_last;
    end else if (cmd.add_do) begin
      out_kind_r    <= free_found ? KIND_ADDED : KIND_FULL;
      out_id_r      <= free_found ? next_id_r : 16'd0;
      out_due_r     <= free_found ? add_due : 32'd0;
      out_handler_r <= HND_OWN;
      out_last_r    <= 1'b1;
    end else if (cmd.cancel_do) begin
      out_kind_r    <= best_found_r ? KIND_CANCELLED : KIND_MISS;
      out_id_r      <= tid_r;
      out_due_r     <= 32'd0;
      out_handler_r <= HND_OWN;
      out_last_r    <= 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r         <= 1'b0;
      dflt_r       <= 1'b0;
      now_r        <= '0;
      next_id_r    <= '0;
      valid_r      <= '0;
      done_r       <= '0;
      nres_r       <= '0;
      have_pend_r  <= 1'b0;
      ra_r         <= '0;
      rv_r         <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_ENABLE) begin
        en_r <= cfg_data[0];
      end
      if (cfg_we && cfg_index == CFG_DEFAULT) begin
        dflt_r <= cfg_data[0];
      end
      if (cmd.accept && in_command == CMD_TICK && en_r) begin
        now_r       <= now_r + 32'd1;
        done_r      <= '0;
        nres_r      <= '0;
        have_pend_r <= 1'b0;
      end
      if (cmd.scan_start) begin
        ra_r         <= '0;
        rv_r         <= 1'b0;
        best_found_r <= 1'b0;
      end else if (cmd.scan_step) begin
        rv_r <= rd_en;
        if (rd_en) begin
          ra_r <= ra_r + 1'b1;
        end
        if (hit) begin
          best_found_r <= 1'b1;
        end
      end
      if (cmd.take_best) begin
        done_r[best_idx_r] <= 1'b1;
        nres_r             <= nres_r + 1'b1;
        have_pend_r        <= 1'b1;
        if (!best_rec_r.periodic) begin
          valid_r[best_idx_r] <= 1'b0;
        end
      end
      if (cmd.add_do && free_found) begin
        valid_r[free_idx] <= 1'b1;
        next_id_r         <= next_id_r + 16'd1;
      end
      if (cmd.cancel_do && best_found_r) begin
        valid_r[best_idx_r] <= 1'b0;
      end
      if (cmd.emit_pend || cmd.add_do || cmd.cancel_do) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.in_op      = opcode_t'(in_command);
  assign stat.en         = en_r;
  assign stat.is_tick    = (op_r == CMD_TICK);
  assign stat.scan_done  = (ra_r == SLOTS_C) && !rv_r;
  assign stat.best_found = best_found_r;
  assign stat.have_pend  = have_pend_r;
  assign stat.cap_next   = (nres_r == NRES_W'(MAX_RESULTS - 1));
  assign stat.out_free   = out_free;

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_id       = out_id_r;
  assign out_due_time = out_due_r;
  assign out_handler  = out_handler_r;
  assign out_last     = out_last_r;

  a_nres_cap: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r <= NRES_W'(MAX_RESULTS))
    else $error("more expiries than the burst cap");
  a_take_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_best |-> best_found_r)
    else $error("expiry taken without a candidate");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_pend || cmd.add_do || cmd.cancel_do) |-> out_free)
    else $error("result register overwritten");
  a_done_set: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_best |=> done_r[$past(best_idx_r)])
    else $error("expired slot not marked done");

endmodule

>>> sv/mtdq_ctrl.sv
// Controller of the multi-timer deadline queue: sequences accept, slot scans,
// expiry bursts and result hand-off. Depends on mtdq_pkg.
module mtdq_ctrl import mtdq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_TEVAL = 6'b000100,
    S_TLAST = 6'b001000,
    S_ADD   = 6'b010000,
    S_CFIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept     = 1'b1;
          cmd.scan_start = 1'b1;
          unique case (stat.in_op)
            CMD_TICK:    state_nxt = stat.en ? S_SCAN : S_IDLE;
            CMD_ADD_REL: state_nxt = S_ADD;
            CMD_ADD_ABS: state_nxt = S_ADD;
            CMD_CANCEL:  state_nxt = S_SCAN;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = stat.is_tick ? S_TEVAL : S_CFIN;
        end
      end
      S_TEVAL: begin
        if (stat.best_found) begin
          if (!stat.have_pend || stat.out_free) begin
            cmd.take_best = 1'b1;
            cmd.emit_pend = stat.have_pend;
            if (stat.cap_next) begin
              state_nxt = S_TLAST;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
        end else begin
          state_nxt = stat.have_pend ? S_TLAST : S_IDLE;
        end
      end
      S_TLAST: begin
        if (stat.out_free) begin
          cmd.emit_pend = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ADD: begin
        if (stat.out_free) begin
          cmd.add_do = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_CFIN: begin
        if (stat.out_free) begin
          cmd.cancel_do = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/multi_timer_deadline_queue_core.sv
// Top level of the multi-timer deadline queue: controller plus datapath.
// Depends on mtdq_pkg, mtdq_if, mtdq_ctrl and mtdq_dp.
//
//   Channel  Direction  Carries
//   in_ch    sink       command, duration, periodic, deadline, timer_id, own_handler
//   out_ch   source     kind, id, due_time, handler, last
//   cfg_ch   sink       index (0 enable, 1 default handler enable), data
//
// A cancel scans every slot once. An enabled tick scans all slots once per expiry
// and, unless the burst cap of MAX_RESULTS expiries is reached, once more to find
// the end; the scan reads the slot memory through its single read port, one slot
// per cycle.
// Reset (rst_n low, synchronous) clears time, the id counter, all slot valid bits
// and the configuration. The output register holds a result while out_ch.ready
// is low; the next item is still accepted and waits only when it needs to emit.
module multi_timer_deadline_queue_core import mtdq_pkg::*; #(
  parameter int TIMER_SLOTS = 16
) (
  input logic            clk,
  input logic            rst_n,
  mtdq_in_if.sink        in_ch,
  mtdq_out_if.source     out_ch,
  mtdq_cfg_if.sink       cfg_ch
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // Config writes always taken; user must do them only while idle, unchecked.
  assign cfg_ch.ready = 1'b1;

  mtdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mtdq_dp #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_command     (in_ch.command),
    .in_duration    (in_ch.duration),
    .in_periodic    (in_ch.periodic),
    .in_deadline    (in_ch.deadline),
    .in_timer_id    (in_ch.timer_id),
    .in_own_handler (in_ch.own_handler),
    .cfg_we         (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_kind       (out_ch.kind),
    .out_id         (out_ch.id),
    .out_due_time   (out_ch.due_time),
    .out_handler    (out_ch.handler),
    .out_last       (out_ch.last)
  );

endmodule
